FILE: src/ccmp_pkg.sv
// Shared types and constants for the CCMP frame decryptor.
package ccmp_pkg;

	// Field widths
	localparam int LEN_W       = 12;
	localparam int CFG_IDX_W   = 8;
	localparam int KEY_HALF_W  = 64;
	localparam int BLK_W       = 128;
	localparam int AAD_W       = 256;
	localparam int PN_W        = 48;
	localparam int TDATA_IN_W  = 24;
	localparam int TDATA_OUT_W = 24;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

	// 802.11 header layout
	localparam logic [5:0] HDR_LEN_BASIC = 6'd24;
	localparam logic [5:0] HDR_LEN_QOS   = 6'd26;
	localparam logic [7:0] AAD_LEN_BASIC = 8'd22;
	localparam logic [7:0] AAD_LEN_QOS   = 8'd24;
	localparam logic [LEN_W-1:0] CCMP_HDR_LEN = 12'd8;
	localparam logic [LEN_W-1:0] MIC_LEN      = 12'd8;
	localparam logic [7:0] QOS_TYPE_MASK = 8'hf0;
	localparam logic [7:0] QOS_TYPE      = 8'h80;
	localparam logic [7:0] FC0_MASK      = 8'h8f;
	localparam logic [7:0] FC1_MASK      = 8'hc7;
	localparam logic [7:0] SEQ_MASK      = 8'h0F;
	localparam logic [7:0] TID_MASK      = 8'h0f;

	// CCM flags bytes
	localparam logic [7:0] FLAGS_MAC = 8'h59;
	localparam logic [7:0] FLAGS_CTR = FLAGS_MAC & 8'h07;

	// Header bytes held by the front end (0..24)
	localparam int HS_DEPTH = 25;
	localparam int HS_IDX_W = $clog2(HS_DEPTH);

	// Queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [3:0] AES_ROUNDS = 4'd10;

	typedef enum logic [1:0] {
		OP_SETUP,
		OP_DATA,
		OP_MIC,
		OP_FAIL
	} fr_op_t;

	// One unit of work for the back end
	typedef struct packed {
		fr_op_t           op;
		logic [7:0]       data;
		logic [3:0]       off;
		logic             mac_end;
		logic             verdict;
		logic [LEN_W-1:0] dlen;
		logic [AAD_W-1:0] aad;
		logic [PN_W-1:0]  pn;
	} fr_entry_t;

	typedef enum logic {
		BK_IDLE,
		BK_AES
	} bk_state_t;

	typedef enum logic [2:0] {
		J_B0,
		J_AAD0,
		J_AAD1,
		J_MASK,
		J_KS,
		J_MAC
	} aes_job_t;

endpackage

FILE: src/ccmp_fifo.sv
// Short show-ahead queue of work entries between front and back.
module ccmp_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ccmp_pkg::fr_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output ccmp_pkg::fr_entry_t head_entry
);
	import ccmp_pkg::*;

	fr_entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	assign full       = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (!push && pop)
				count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

FILE: src/ccmp_front.sv
// Front end: takes frame bytes, captures the header and queues work entries.
module ccmp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 frame_byte,
	input  logic [ccmp_pkg::LEN_W-1:0] frame_length,
	input  logic                       q_full,
	output logic                       push,
	output ccmp_pkg::fr_entry_t        entry
);
	import ccmp_pkg::*;

	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic             qos_q;
	logic [7:0]       hs_q [HS_DEPTH];
	logic [55:0]      last7_q;

	logic             acc;
	logic             cur_qos;
	logic [LEN_W-1:0] cur_len;
	logic [LEN_W-1:0] hlen;
	logic [LEN_W-1:0] endpos;
	logic [LEN_W-1:0] dstart;
	logic [LEN_W-1:0] dend;
	logic [LEN_W-1:0] dofs;
	logic             is_short;
	logic             is_last;
	logic [AAD_W-1:0] aad;

	assign in_ready = !q_full;
	assign acc      = in_valid && !q_full;

	// Classify the current byte
	always_comb begin
		cur_qos  = (pos_q == '0) ? ((frame_byte & QOS_TYPE_MASK) == QOS_TYPE) : qos_q;
		cur_len  = (pos_q == '0) ? frame_length : len_q;
		hlen     = cur_qos ? LEN_W'(HDR_LEN_QOS) : LEN_W'(HDR_LEN_BASIC);
		endpos   = (cur_len == '0) ? '0 : cur_len - 1'b1;
		is_last  = (pos_q >= endpos);
		is_short = (cur_len < hlen + CCMP_HDR_LEN + MIC_LEN);
		dstart   = hlen + CCMP_HDR_LEN;
		dend     = cur_len - MIC_LEN;
		dofs     = pos_q - dstart;
	end

	// Masked AAD from the captured header
	always_comb begin
		aad            = '0;
		aad[247:240]   = qos_q ? AAD_LEN_QOS : AAD_LEN_BASIC;
		aad[239:232]   = hs_q[0] & FC0_MASK;
		aad[231:224]   = hs_q[1] & FC1_MASK;
		for (int i = 0; i < 18; i++)
			aad[(27-i)*8 +: 8] = hs_q[4+i];
		aad[79:72]     = hs_q[22] & SEQ_MASK;
		aad[63:56]     = qos_q ? (hs_q[24] & TID_MASK) : 8'h00;
	end

	// Work entry
	always_comb begin
		entry.op      = OP_FAIL;
		entry.data    = frame_byte;
		entry.off     = dofs[3:0];
		entry.mac_end = (dofs[3:0] == 4'hf) || (pos_q == dend - 1'b1);
		entry.verdict = is_last;
		entry.dlen    = dend - dstart;
		entry.aad     = aad;
		entry.pn      = {frame_byte, last7_q[7:0], last7_q[15:8], last7_q[23:16],
			last7_q[47:40], last7_q[55:48]};
		push          = 1'b0;
		if (is_short) begin
			entry.dlen = '0;
			push       = acc && is_last;
		end else if (pos_q == dstart - 1'b1) begin
			entry.op = OP_SETUP;
			push     = acc;
		end else if (pos_q >= dstart && pos_q < dend) begin
			entry.op = OP_DATA;
			push     = acc;
		end else if (pos_q >= dend) begin
			entry.op = OP_MIC;
			push     = acc;
		end
	end

	// Frame position and per-frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
			qos_q <= 1'b0;
		end else if (acc) begin
			pos_q <= is_last ? '0 : pos_q + 1'b1;
			if (pos_q == '0) begin
				len_q <= frame_length;
				qos_q <= cur_qos;
			end
		end
	end

	// Header capture and packet-number shift line
	always_ff @(posedge clk) begin
		if (acc) begin
			last7_q <= {last7_q[47:0], frame_byte};
			if (pos_q < LEN_W'(HS_DEPTH))
				hs_q[pos_q[HS_IDX_W-1:0]] <= frame_byte;
		end
	end

endmodule

FILE: src/ccmp_aes.sv
// Round-iterated AES-128 encryption core with on-the-fly key schedule.
module ccmp_aes (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ccmp_pkg::BLK_W-1:0] blk_in,
	input  logic [ccmp_pkg::BLK_W-1:0] key,
	output logic                       done,
	output logic [ccmp_pkg::BLK_W-1:0] blk_out
);
	import ccmp_pkg::*;

	localparam logic [2047:0] SBOX_TBL = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX_TBL[{~x, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] gmul2(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [BLK_W-1:0] next_rk(input logic [BLK_W-1:0] rk,
			input logic [7:0] rc);
		logic [31:0] tw, n0, n1, n2, n3;
		tw = {sbox(rk[23:16]) ^ rc, sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
		n0 = rk[127:96] ^ tw;
		n1 = rk[95:64] ^ n0;
		n2 = rk[63:32] ^ n1;
		n3 = rk[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	logic             busy_q;
	logic             done_q;
	logic [3:0]       rnd_q;
	logic [7:0]       rcon_q;
	logic [BLK_W-1:0] rk_q;
	logic [BLK_W-1:0] st_q;

	logic [BLK_W-1:0] rk_n;
	logic [BLK_W-1:0] st_n;
	logic [7:0]       s [16];
	logic [7:0]       t [16];
	logic [7:0]       m [16];
	logic [7:0]       x;

	assign done    = done_q;
	assign blk_out = st_q;

	// One round: SubBytes, ShiftRows, MixColumns (not in the last round), AddRoundKey
	always_comb begin
		x    = '0;
		rk_n = next_rk(rk_q, rcon_q);
		for (int i = 0; i < 16; i++)
			s[i] = st_q[(15-i)*8 +: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[r+4*c] = sbox(s[r + 4*((c+r) & 3)]);
		for (int c = 0; c < 4; c++) begin
			x          = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
			m[4*c]     = t[4*c]   ^ x ^ gmul2(t[4*c]   ^ t[4*c+1]);
			m[4*c+1]   = t[4*c+1] ^ x ^ gmul2(t[4*c+1] ^ t[4*c+2]);
			m[4*c+2]   = t[4*c+2] ^ x ^ gmul2(t[4*c+2] ^ t[4*c+3]);
			m[4*c+3]   = t[4*c+3] ^ x ^ gmul2(t[4*c+3] ^ t[4*c]);
		end
		for (int i = 0; i < 16; i++)
			st_n[(15-i)*8 +: 8] = ((rnd_q == AES_ROUNDS) ? t[i] : m[i]) ^ rk_n[(15-i)*8 +: 8];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= 4'd1;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == AES_ROUNDS) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			st_q   <= blk_in ^ key;
			rk_q   <= key;
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			st_q   <= st_n;
			rk_q   <= rk_n;
			rcon_q <= gmul2(rcon_q);
		end
	end

endmodule

FILE: src/ccmp_back.sv
// Back end: CTR decryption, CBC-MAC and verdict, sharing one AES core.
module ccmp_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ccmp_pkg::BLK_W-1:0]     key,
	input  logic                           q_valid,
	input  ccmp_pkg::fr_entry_t            q_entry,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           out_kind,
	output logic [7:0]                     out_plain,
	output logic                           out_mic_ok,
	output logic [ccmp_pkg::LEN_W-1:0]     out_plain_length,
	output logic                           out_last
);
	import ccmp_pkg::*;

	bk_state_t        state_q, state_d;
	aes_job_t         job_q, job_d;
	logic             ks_ok_q;
	logic [BLK_W-1:0] mac_q;
	logic [BLK_W-1:0] ks_q;
	logic [15:0]      ctr_q;
	logic [63:0]      mask_q;
	logic [63:0]      rxmic_q;
	logic [AAD_W-1:0] aad_q;
	logic [PN_W-1:0]  pn_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic [7:0]       out_plain_q;
	logic             out_ok_q;
	logic [LEN_W-1:0] out_len_q;

	logic             aes_start;
	logic [BLK_W-1:0] aes_in;
	logic             aes_done;
	logic [BLK_W-1:0] aes_res;
	logic             ks_start;
	logic             setup_take;
	logic             emit;
	logic             emit_kind;
	logic             emit_ok;
	logic             out_free;
	logic [7:0]       pbyte;
	logic [BLK_W-1:0] mac_nxt;
	logic [63:0]      rx_nxt;
	logic [BLK_W-1:0] ctr_blk;
	logic [BLK_W-1:0] mask_blk;

	ccmp_aes u_aes (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (aes_start),
		.blk_in  (aes_in),
		.key     (key),
		.done    (aes_done),
		.blk_out (aes_res)
	);

	assign out_free = !out_valid_q || out_ready;
	assign pbyte    = q_entry.data ^ ks_q[{~q_entry.off, 3'b000} +: 8];
	assign mac_nxt  = mac_q ^ (BLK_W'(pbyte) << {~q_entry.off, 3'b000});
	assign rx_nxt   = {rxmic_q[55:0], q_entry.data};
	assign ctr_blk  = {FLAGS_CTR, aad_q[63:56], aad_q[175:128], pn_q, ctr_q};
	assign mask_blk = {FLAGS_CTR, aad_q[63:56], aad_q[175:128], pn_q, 16'h0000};

	// Next state and control
	always_comb begin
		state_d    = state_q;
		job_d      = job_q;
		aes_start  = 1'b0;
		aes_in     = mac_nxt;
		ks_start   = 1'b0;
		setup_take = 1'b0;
		q_pop      = 1'b0;
		emit       = 1'b0;
		emit_kind  = 1'b0;
		emit_ok    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					unique case (q_entry.op)
						OP_SETUP: begin
							setup_take = 1'b1;
							q_pop      = 1'b1;
							aes_start  = 1'b1;
							aes_in     = {FLAGS_MAC, q_entry.aad[63:56], q_entry.aad[175:128],
								q_entry.pn, 4'h0, q_entry.dlen};
							job_d      = J_B0;
							state_d    = BK_AES;
						end
						OP_DATA: begin
							if (q_entry.off == 4'h0 && !ks_ok_q) begin
								ks_start  = 1'b1;
								aes_start = 1'b1;
								aes_in    = ctr_blk;
								job_d     = J_KS;
								state_d   = BK_AES;
							end else if (out_free) begin
								q_pop = 1'b1;
								emit  = 1'b1;
								if (q_entry.mac_end) begin
									aes_start = 1'b1;
									aes_in    = mac_nxt;
									job_d     = J_MAC;
									state_d   = BK_AES;
								end
							end
						end
						OP_MIC: begin
							if (!q_entry.verdict) begin
								q_pop = 1'b1;
							end else if (out_free) begin
								q_pop     = 1'b1;
								emit      = 1'b1;
								emit_kind = 1'b1;
								emit_ok   = ((rx_nxt ^ mask_q) == mac_q[127:64]);
							end
						end
						OP_FAIL: begin
							if (out_free) begin
								q_pop     = 1'b1;
								emit      = 1'b1;
								emit_kind = 1'b1;
							end
						end
					endcase
				end
			end
			BK_AES: begin
				if (aes_done) begin
					unique case (job_q)
						J_B0: begin
							aes_start = 1'b1;
							aes_in    = aes_res ^ aad_q[255:128];
							job_d     = J_AAD0;
						end
						J_AAD0: begin
							aes_start = 1'b1;
							aes_in    = aes_res ^ aad_q[127:0];
							job_d     = J_AAD1;
						end
						J_AAD1: begin
							aes_start = 1'b1;
							aes_in    = mask_blk;
							job_d     = J_MASK;
						end
						J_MASK, J_KS, J_MAC: state_d = BK_IDLE;
						default:             state_d = BK_IDLE;
					endcase
				end
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			job_q       <= J_B0;
			ks_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			if (state_q == BK_AES && aes_done && job_q == J_KS)
				ks_ok_q <= 1'b1;
			else if (q_pop && q_entry.op == OP_DATA)
				ks_ok_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Frame datapath
	always_ff @(posedge clk) begin
		if (setup_take) begin
			aad_q   <= q_entry.aad;
			pn_q    <= q_entry.pn;
			ctr_q   <= 16'h0001;
			rxmic_q <= '0;
		end
		if (ks_start)
			ctr_q <= ctr_q + 1'b1;
		if (q_pop && q_entry.op == OP_DATA)
			mac_q <= mac_nxt;
		if (q_pop && q_entry.op == OP_MIC)
			rxmic_q <= rx_nxt;
		if (state_q == BK_AES && aes_done) begin
			if (job_q == J_AAD1 || job_q == J_MAC)
				mac_q <= aes_res;
			if (job_q == J_MASK)
				mask_q <= aes_res[127:64];
			if (job_q == J_KS)
				ks_q <= aes_res;
		end
		if (emit) begin
			out_kind_q  <= emit_kind;
			out_plain_q <= emit_kind ? 8'h00 : pbyte;
			out_ok_q    <= emit_ok;
			out_len_q   <= emit_kind ? q_entry.dlen : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_kind         = out_kind_q;
	assign out_plain        = out_plain_q;
	assign out_mic_ok       = out_ok_q;
	assign out_plain_length = out_len_q;
	assign out_last         = out_kind_q;

endmodule

FILE: src/ccmp_frame_decrypt.sv
// Top level of the CCMP (AES-128 CCM) receive frame decryptor.
//
// Input stream: one frame byte per transaction, header first and MIC last;
// tdata[19:8] carries the frame length, sampled on the first byte.
// Output stream: one transaction per plaintext byte (tuser 0), then one
// verdict (tuser 1, tlast 1) carrying the MIC match and plaintext length.
// The key is loaded through the cfg channel (index 0 high half, 1 low half);
// the user must load it only while no frame is in flight, which the block does
// not enforce; cfg_ready is always high. Header bytes are taken at one per
// cycle while the queue is not full. Once the CCMP header is in, the back end
// runs four chained AES operations for B0, the AAD and the MIC mask. Each
// 16-byte data block then costs two AES operations on the single
// round-iterated core; the four-entry queue lets the input run ahead of that.
// A result reaches the output register in the cycle after its entry is
// handled. A stalled receiver holds the output register; the queue keeps
// filling until full, then s_axis_tready drops. Reset clears the frame
// position, queue pointers, control state and the key, but not the datapath
// registers; no clearing pass is needed.
module ccmp_frame_decrypt (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [ccmp_pkg::TDATA_IN_W-1:0]      s_axis_tdata,  // frame_byte, frame_length
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [ccmp_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,  // plain_byte, mic_ok, plain_length
	output logic                                 m_axis_tuser,  // kind
	output logic                                 m_axis_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ccmp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ccmp_pkg::KEY_HALF_W-1:0]      cfg_data
);
	import ccmp_pkg::*;

	logic [KEY_HALF_W-1:0] key_high_q;
	logic [KEY_HALF_W-1:0] key_low_q;

	logic             q_full;
	logic             q_push;
	fr_entry_t        q_in;
	logic             q_pop;
	logic             q_valid;
	fr_entry_t        q_head;
	logic [7:0]       plain;
	logic             mic_ok;
	logic [LEN_W-1:0] plain_len;

	assign cfg_ready = 1'b1;

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_KEY_HIGH)
				key_high_q <= cfg_data;
			else if (cfg_index == REG_KEY_LOW)
				key_low_q <= cfg_data;
		end
	end

	ccmp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.frame_byte   (s_axis_tdata[7:0]),
		.frame_length (s_axis_tdata[19:8]),
		.q_full       (q_full),
		.push         (q_push),
		.entry        (q_in)
	);

	ccmp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_entry (q_head)
	);

	ccmp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.key              ({key_high_q, key_low_q}),
		.q_valid          (q_valid),
		.q_entry          (q_head),
		.q_pop            (q_pop),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_kind         (m_axis_tuser),
		.out_plain        (plain),
		.out_mic_ok       (mic_ok),
		.out_plain_length (plain_len),
		.out_last         (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, plain_len, mic_ok, plain};

endmodule

FILE: bench/ccmp_tb_aes_pkg.sv
// AES-128 block encryption helpers used by the CCMP frame checker.
`timescale 1ns / 100ps

package ccmp_tb_aes_pkg;

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= a;
			a = xtime(a);
		end
		return acc;
	endfunction

	// S-box: inverse as x^254, then the affine map
	function automatic logic [7:0] sub_byte(input logic [7:0] x);
		logic [7:0] inv, base;
		int e;
		inv = 8'h01;
		base = x;
		e = 254;
		while (e != 0) begin
			if (e & 1)
				inv = gf_mul(inv, base);
			base = gf_mul(base, base);
			e = e >> 1;
		end
		return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
			^ {inv[3:0], inv[7:4]} ^ 8'h63;
	endfunction

	// One block, byte 0 in the top bits of both key and data
	function automatic logic [127:0] aes128_enc(input logic [127:0] key,
			input logic [127:0] din);
		logic [7:0] rk [176];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] w [4];
		logic [7:0] rc, f, a0, a1, a2, a3, x;
		logic [127:0] dout;
		rc = 8'h01;
		for (int i = 0; i < 16; i++)
			rk[i] = key[127-8*i -: 8];
		for (int i = 4; i < 44; i++) begin
			for (int c = 0; c < 4; c++)
				w[c] = rk[4*(i-1)+c];
			if ((i & 3) == 0) begin
				f = w[0];
				w[0] = sub_byte(w[1]) ^ rc;
				w[1] = sub_byte(w[2]);
				w[2] = sub_byte(w[3]);
				w[3] = sub_byte(f);
				rc = xtime(rc);
			end
			for (int c = 0; c < 4; c++)
				rk[4*i+c] = rk[4*(i-4)+c] ^ w[c];
		end
		for (int i = 0; i < 16; i++)
			s[i] = din[127-8*i -: 8] ^ rk[i];
		for (int r = 1; r <= 10; r++) begin
			// SubBytes with ShiftRows
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[i+4*c] = sub_byte(s[i+4*((c+i)&3)]);
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c];
					a1 = t[4*c+1];
					a2 = t[4*c+2];
					a3 = t[4*c+3];
					x = a0 ^ a1 ^ a2 ^ a3;
					t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
					t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
					t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
					t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				s[i] = t[i] ^ rk[16*r+i];
		end
		for (int i = 0; i < 16; i++)
			dout[127-8*i -: 8] = s[i];
		return dout;
	endfunction

endpackage

FILE: bench/ccmp_frame_checker.sv
// Scoreboard for the CCMP decryptor: predicts each output transaction and compares.
`timescale 1ns / 100ps

module ccmp_frame_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [ccmp_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [ccmp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
	input  logic                             m_axis_tuser,
	input  logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [ccmp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ccmp_pkg::KEY_HALF_W-1:0]  cfg_data,
	output int                               fail_count,
	output int                               pending,
	output logic [63:0]                      good_mic,   // MIC a sender must append now
	output int                               plain_seen,
	output int                               verdict_seen,
	output int                               mic_ok_seen
);
	import ccmp_pkg::*;
	import ccmp_tb_aes_pkg::*;

	typedef struct packed {
		logic             kind;
		logic [7:0]       plain;
		logic             ok;
		logic [LEN_W-1:0] plen;
		logic             last;
	} rx_item_t;

	rx_item_t expected_q [$];

	// Predicted decryptor state
	logic [127:0] key;
	logic [7:0]   hdr [34];
	int           pos, frame_len;
	logic         qos;
	logic [127:0] mac, keystream;
	logic [15:0]  ctr;
	logic [63:0]  mic_mask, rx_mic;

	assign good_mic = mic_mask ^ mac[127:64];

	// Counter or B0 block built from the captured header
	function automatic logic [127:0] nonce_block(input logic [7:0] flags, input int hl,
			input logic [15:0] tail);
		logic [127:0] b;
		b[127:120] = flags;
		b[119:112] = qos ? (hdr[24] & TID_MASK) : 8'h00;
		for (int i = 0; i < 6; i++)
			b[111-8*i -: 8] = hdr[10+i];
		b[63:56] = hdr[hl+7];
		b[55:48] = hdr[hl+6];
		b[47:40] = hdr[hl+5];
		b[39:32] = hdr[hl+4];
		b[31:24] = hdr[hl+1];
		b[23:16] = hdr[hl];
		b[15:0]  = tail;
		return b;
	endfunction

	// B0, masked AAD and MIC mask, once the CCMP header is in
	task automatic start_mac(input int hl, input int dl);
		logic [255:0] aad;
		aad = '0;
		aad[247:240] = qos ? AAD_LEN_QOS : AAD_LEN_BASIC;
		aad[239:232] = hdr[0] & FC0_MASK;
		aad[231:224] = hdr[1] & FC1_MASK;
		for (int i = 0; i < 18; i++)
			aad[223-8*i -: 8] = hdr[4+i];
		aad[79:72] = hdr[22] & SEQ_MASK;
		if (qos)
			aad[63:56] = hdr[24] & TID_MASK;
		mac = aes128_enc(key, nonce_block(FLAGS_MAC, hl, dl[15:0]));
		mac = aes128_enc(key, mac ^ aad[255:128]);
		mac = aes128_enc(key, mac ^ aad[127:0]);
		keystream = aes128_enc(key, nonce_block(FLAGS_CTR, hl, 16'd0));
		mic_mask = keystream[127:64];
		ctr = 16'd1;
	endtask

	task automatic decrypt_byte(input logic [7:0] b, input logic [LEN_W-1:0] flen);
		int p, hl, endp, dl, d, o;
		logic shrt, ok;
		logic [7:0] pb;
		rx_item_t r;
		if (pos == 0) begin
			frame_len = flen;
			qos = (b & QOS_TYPE_MASK) == QOS_TYPE;
			rx_mic = '0;
			ctr = 16'd1;
			mac = '0;
		end
		p = pos;
		hl = qos ? HDR_LEN_QOS : HDR_LEN_BASIC;
		endp = (frame_len == 0) ? 0 : frame_len - 1;
		if (p < 34)
			hdr[p] = b;
		shrt = frame_len < hl + 16;
		dl = 0;
		if (!shrt) begin
			dl = frame_len - hl - 16;
			if (p == hl + 7) begin
				start_mac(hl, dl);
			end else if (p >= hl + 8 && p < hl + 8 + dl) begin
				d = p - hl - 8;
				o = d & 15;
				if (o == 0) begin
					keystream = aes128_enc(key, nonce_block(FLAGS_CTR, hl, ctr));
					ctr = ctr + 16'd1;
				end
				pb = b ^ keystream[127-8*o -: 8];
				mac[127-8*o -: 8] = mac[127-8*o -: 8] ^ pb;
				if (o == 15 || d == dl - 1)
					mac = aes128_enc(key, mac);
				r = '{kind: 1'b0, plain: pb, ok: 1'b0, plen: '0, last: 1'b0};
				expected_q.push_back(r);
			end else if (p >= hl + 8 + dl) begin
				rx_mic = {rx_mic[55:0], b};
			end
		end
		if (p >= endp) begin
			ok = !shrt && ((rx_mic ^ mic_mask) == mac[127:64]);
			r = '{kind: 1'b1, plain: 8'h00, ok: ok, plen: shrt ? '0 : dl[LEN_W-1:0],
				last: 1'b1};
			expected_q.push_back(r);
			pos = 0;
		end else begin
			pos = (p + 1) & 12'hfff;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rx_item_t got, want;
		if (!arst_n) begin
			key = '0;
			pos = 0;
			frame_len = 0;
			qos = 1'b0;
			mac = '0;
			keystream = '0;
			ctr = 16'd1;
			mic_mask = '0;
			rx_mic = '0;
			for (int i = 0; i < 34; i++)
				hdr[i] = 8'h00;
			expected_q.delete();
			pending = 0;
			fail_count = 0;
			plain_seen = 0;
			verdict_seen = 0;
			mic_ok_seen = 0;
		end else begin
			// key register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_KEY_HIGH)
					key[127:64] = cfg_data;
				else if (cfg_index == REG_KEY_LOW)
					key[63:0] = cfg_data;
			end
			// input transaction
			if (s_axis_tvalid && s_axis_tready)
				decrypt_byte(s_axis_tdata[7:0], s_axis_tdata[19:8]);
			// output transaction
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{kind: m_axis_tuser, plain: m_axis_tdata[7:0], ok: m_axis_tdata[8],
					plen: m_axis_tdata[20:9], last: m_axis_tlast};
				if (got.kind)
					verdict_seen++;
				else
					plain_seen++;
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result kind=%0d byte=%02h ok=%0d len=%0d",
							$realtime, got.kind, got.plain, got.ok, got.plen);
				end else begin
					want = expected_q.pop_front();
					if (want.kind && want.ok)
						mic_ok_seen++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: mismatch exp kind=%0d byte=%02h ok=%0d len=%0d",
								" last=%0d, got kind=%0d byte=%02h ok=%0d len=%0d last=%0d"},
								$realtime, want.kind, want.plain, want.ok, want.plen,
								want.last, got.kind, got.plain, got.ok, got.plen, got.last);
					end
				end
			end
			// outstanding predictions
			pending = expected_q.size();
		end
	end

endmodule

FILE: bench/ccmp_frame_decrypt_tb.sv
// Testbench top for the CCMP frame decryptor: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module ccmp_frame_decrypt_tb;
	import ccmp_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_TARGET = 1450;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata;   // frame_byte, frame_length
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;   // plain_byte, mic_ok, plain_length
	logic                   m_axis_tuser;   // kind
	logic                   m_axis_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [KEY_HALF_W-1:0]  cfg_data;

	int          fail_count, pending, plain_seen, verdict_seen, mic_ok_seen;
	logic [63:0] good_mic;
	int          bytes_sent, frames_sent, cycles, hold_left, burst_left;
	logic        quiet, held;

	ccmp_frame_decrypt dut (.*);

	ccmp_frame_checker chk (.*);

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Timeout guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off mid-run, none at the end
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			burst_left <= 0;
			held <= 1'b0;
		end else if (!held && bytes_sent >= 700) begin
			held <= 1'b1;
			hold_left <= 400;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (burst_left != 0) begin
			burst_left <= burst_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			burst_left <= $urandom_range(0, 3);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// One input transaction, with an occasional idle burst in front
	task automatic send_byte(input logic [7:0] b, input logic [LEN_W-1:0] flen);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'h0, flen, b};
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every expected result, then let the back end drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Whole frame: declared length, QoS or not, MIC good or corrupted.
	// A declared length of 0 or 1 is a single byte.
	task automatic send_frame(input int flen, input bit is_qos, input bit mic_good);
		int hl, n, mic_at;
		logic [7:0] b;
		logic [3:0] nib;
		logic [63:0] mic;
		hl = is_qos ? HDR_LEN_QOS : HDR_LEN_BASIC;
		n = (flen < 2) ? 1 : flen;
		mic_at = (flen >= hl + 16) ? flen - 8 : n;
		do nib = $urandom_range(0, 15); while (nib == 4'h8);
		for (int i = 0; i < n; i++) begin
			if (i == mic_at && mic_good) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				mic = good_mic;
			end else if (i == mic_at) begin
				mic = good_mic ^ (64'h1 << $urandom_range(0, 63));
			end
			if (i == 0)
				b = is_qos ? {4'h8, 4'($urandom_range(0, 15))}
					: {nib, 4'($urandom_range(0, 15))};
			else if (i >= mic_at)
				b = mic[63 - 8*(i - mic_at) -: 8];
			else
				b = $urandom_range(0, 255);
			send_byte(b, (i == 0) ? flen[LEN_W-1:0] : LEN_W'($urandom_range(0, 4095)));
		end
		frames_sent++;
	endtask

	// Random mix: mostly well-formed frames, some bad MICs and short ones
	task automatic random_frame();
		int sel, hl, dl;
		bit q;
		q = $urandom_range(0, 1);
		hl = q ? HDR_LEN_QOS : HDR_LEN_BASIC;
		sel = $urandom_range(0, 99);
		dl = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 48);
		if (sel < 70)
			send_frame(hl + 16 + dl, q, 1'b1);
		else if (sel < 85)
			send_frame(hl + 16 + dl, q, 1'b0);
		else
			send_frame($urandom_range(0, hl + 15), q, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		bytes_sent = 0;
		frames_sent = 0;
		cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: degenerate and short frames, the smallest full frame, QoS frames, reset key
		send_frame(0, 1'b0, 1'b0);
		send_frame(1, 1'b1, 1'b0);
		send_frame(5, 1'b1, 1'b0);
		send_frame(HDR_LEN_BASIC + 15, 1'b0, 1'b0);
		send_frame(HDR_LEN_BASIC + 16, 1'b0, 1'b1);
		send_frame(HDR_LEN_QOS + 16 + 17, 1'b1, 1'b1);
		send_frame(HDR_LEN_QOS + 16 + 32, 1'b1, 1'b0);
		settle();

		// All-ones key, plus a write to an unused index
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_KEY_LOW, '1);
		write_reg(CFG_IDX_W'(2), 64'h0123_4567_89ab_cdef);
		send_frame(HDR_LEN_BASIC + 16 + 16, 1'b0, 1'b1);
		send_frame(HDR_LEN_QOS + 16 + 3, 1'b1, 1'b1);

		// Random phases, each with a fresh key
		while (bytes_sent < ITEM_TARGET) begin
			settle();
			write_reg(REG_KEY_HIGH, {$urandom, $urandom});
			write_reg(REG_KEY_LOW, {$urandom, $urandom});
			for (int k = 0; k < 8 && bytes_sent < ITEM_TARGET; k++) begin
				if (bytes_sent > ITEM_TARGET - 200)
					quiet <= 1'b1;
				random_frame();
			end
		end
		settle();

		$display("Sent %0d frames (%0d bytes) under several keys, with stalls on both sides.",
			frames_sent, bytes_sent);
		$display("Checked %0d plaintext bytes and %0d verdicts, %0d with a matching MIC.",
			plain_seen, verdict_seen, mic_ok_seen);
		if (fail_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: sim.f
src/ccmp_pkg.sv
src/ccmp_fifo.sv
src/ccmp_front.sv
src/ccmp_aes.sv
src/ccmp_back.sv
src/ccmp_frame_decrypt.sv
bench/ccmp_tb_aes_pkg.sv
bench/ccmp_frame_checker.sv
bench/ccmp_frame_decrypt_tb.sv
